@@ design/kdr_pkg.sv @@
// Keypad decode/debounce package: shared types, register map, key product table.
// No dependencies; imported by all keypad_decode_debounce_repeat modules.
`timescale 1ns / 1ps
package kdr_pkg;

    localparam int KEY_COUNT = 16;
    localparam int KEY_W     = 5;
    localparam int CNT_W     = 8;
    localparam int LINE_W    = 4;
    localparam int PROD_W    = 8;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_CONFIRM = 2'd0;
    localparam logic [1:0] REG_REPEAT  = 2'd1;
    localparam logic [1:0] REG_RELEASE = 2'd2;

    localparam logic [CNT_W-1:0] CONFIRM_RST = 8'd3;
    localparam logic [CNT_W-1:0] REPEAT_RST  = 8'd48;
    localparam logic [CNT_W-1:0] RELEASE_RST = 8'd2;

    typedef struct packed {
        logic [CNT_W-1:0] confirm_count;
        logic [CNT_W-1:0] repeat_threshold;
        logic [CNT_W-1:0] release_limit;
    } cfg_t;

    typedef logic [PROD_W-1:0] prod_t;

    // (col+1)*row signature of each key, key number = index + 1
    function automatic prod_t key_product(input logic [KEY_W-2:0] idx);
        prod_t p;
        case (idx)
            4'd0:    p = 8'd88;
            4'd1:    p = 8'd44;
            4'd2:    p = 8'd80;
            4'd3:    p = 8'd22;
            4'd4:    p = 8'd40;
            4'd5:    p = 8'd72;
            4'd6:    p = 8'd36;
            4'd7:    p = 8'd10;
            4'd8:    p = 8'd104;
            4'd9:    p = 8'd52;
            4'd10:   p = 8'd26;
            4'd11:   p = 8'd20;
            4'd12:   p = 8'd18;
            4'd13:   p = 8'd13;
            4'd14:   p = 8'd9;
            4'd15:   p = 8'd11;
            default: p = 8'd0;
        endcase
        return p;
    endfunction

endpackage

@@ design/keypad_decode_debounce_repeat_unit.sv @@
// Top level: APB register file, scan input register, decoder, tracker, result register.
// Depends on kdr_pkg, kdr_decode, kdr_track.
// Path from input beat to result beat: input register, then result register.
// Throughput: one beat per cycle while out_ready is high; the result register frees
//   the input side so a new scan is taken while a finished result waits.
// Reset: rst_n asynchronous active low; registers return to 3/48/2, counters and
//   tracked key to zero, both stages empty.
`timescale 1ns / 1ps
module keypad_decode_debounce_repeat_unit
    import kdr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [LINE_W-1:0] row_lines,
    input  logic [LINE_W-1:0] col_lines,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [KEY_W-1:0]  key_code
);

    cfg_t              cfg_reg;
    logic [1:0]        reg_idx;
    logic              cfg_wr;

    logic              s1_valid_reg;
    logic [LINE_W-1:0] row_reg;
    logic [LINE_W-1:0] col_reg;
    logic              out_valid_reg;
    logic [KEY_W-1:0]  key_code_reg;

    logic              advance;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  report;

    // ---- configuration port ----
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.confirm_count    <= CONFIRM_RST;
            cfg_reg.repeat_threshold <= REPEAT_RST;
            cfg_reg.release_limit    <= RELEASE_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_CONFIRM: cfg_reg.confirm_count    <= pwdata[CNT_W-1:0];
                REG_REPEAT:  cfg_reg.repeat_threshold <= pwdata[CNT_W-1:0];
                REG_RELEASE: cfg_reg.release_limit    <= pwdata[CNT_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CONFIRM: prdata = DATA_W'(cfg_reg.confirm_count);
            REG_REPEAT:  prdata = DATA_W'(cfg_reg.repeat_threshold);
            REG_RELEASE: prdata = DATA_W'(cfg_reg.release_limit);
            default:     prdata = '0;
        endcase
    end

    // ---- pipeline control ----
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            row_reg <= row_lines;
            col_reg <= col_lines;
        end
        if (advance)
            key_code_reg <= report;
    end

    kdr_decode u_decode (
        .row_lines (row_reg),
        .col_lines (col_reg),
        .key       (key)
    );

    kdr_track u_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .advance (advance),
        .key     (key),
        .report  (report)
    );

    assign out_valid = out_valid_reg;
    assign key_code  = key_code_reg;

endmodule

@@ design/kdr_decode.sv @@
// Scan decoder: row/column sample to key number 0..16.
// Depends on kdr_pkg (product table).
`timescale 1ns / 1ps
module kdr_decode
    import kdr_pkg::*;
(
    input  logic [LINE_W-1:0] row_lines,
    input  logic [LINE_W-1:0] col_lines,
    output logic [KEY_W-1:0]  key
);

    logic [LINE_W-1:0] col_eff;
    logic [LINE_W:0]   col_inc;
    prod_t             prod;

    assign col_eff = (row_lines == '0) ? '0 : col_lines;
    assign col_inc = {1'b0, col_eff} + (LINE_W+1)'(1);
    // max 16*15 = 240, fits the product width
    assign prod    = PROD_W'(col_inc) * PROD_W'(row_lines);

    // highest index first so the lowest matching entry wins
    always_comb
    begin
        key = '0;
        for (int k = KEY_COUNT - 1; k >= 0; k--)
        begin
            if (prod == key_product((KEY_W-1)'(k)))
            begin
                key = KEY_W'(k + 1);
            end
        end
    end

endmodule

@@ design/kdr_track.sv @@
// Debounce and auto-repeat tracker: press/release counters and report logic.
// Depends on kdr_pkg (cfg_t, widths).
`timescale 1ns / 1ps
module kdr_track
    import kdr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             advance,
    input  logic [KEY_W-1:0] key,
    output logic [KEY_W-1:0] report
);

    logic [KEY_W-1:0] last_key_reg,      last_key_next;
    logic [CNT_W-1:0] press_count_reg,   press_count_next;
    logic [CNT_W-1:0] release_count_reg, release_count_next;
    logic [CNT_W-1:0] press_inc;

    assign press_inc = press_count_reg + CNT_W'(1);

    always_comb
    begin
        last_key_next      = last_key_reg;
        press_count_next   = press_count_reg;
        release_count_next = release_count_reg;
        report             = '0;
        if (key == '0)
        begin
            if (press_count_reg != '0)
            begin
                if (release_count_reg < cfg.release_limit)
                    release_count_next = release_count_reg + CNT_W'(1);
                else
                    press_count_next = '0;
            end
        end
        else if (key != last_key_reg)
        begin
            last_key_next      = key;
            press_count_next   = '0;
            release_count_next = '0;
        end
        else
        begin
            release_count_next = '0;
            press_count_next   = press_inc;
            if (press_inc == cfg.confirm_count)
            begin
                report = key;
            end
            else if (press_inc >= cfg.repeat_threshold)
            begin
                // clamp so the repeat keeps firing every tick
                press_count_next = cfg.repeat_threshold - CNT_W'(1);
                report           = key;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_key_reg      <= '0;
            press_count_reg   <= '0;
            release_count_reg <= '0;
        end
        else if (advance)
        begin
            last_key_reg      <= last_key_next;
            press_count_reg   <= press_count_next;
            release_count_reg <= release_count_next;
        end
    end

    // a report always names the key being held
    a_report_is_held: assert property (@(posedge clk) disable iff (!rst_n)
        advance && report != '0 |=> last_key_reg == $past(key))
        else $error("reported key differs from tracked key");

    // empty scans never change the tracked key
    a_empty_keeps_key: assert property (@(posedge clk) disable iff (!rst_n)
        advance && key == '0 |=> $stable(last_key_reg))
        else $error("empty scan changed tracked key");

    // a new key restarts both counters and reports nothing
    a_new_key_restart: assert property (@(posedge clk) disable iff (!rst_n)
        advance && key != '0 && key != last_key_reg
        |-> report == '0 ##1 press_count_reg == '0 && release_count_reg == '0)
        else $error("new key did not restart counters");

endmodule

@@ tb/sv/keypad_decode_debounce_repeat_unit_test.sv @@
// Testbench for keypad_decode_debounce_repeat_unit: scan beats in, key codes out,
// checked against an in-bench key tracker model; config written over APB between phases.
// Depends on kdr_pkg and the design top level.
`timescale 1ns / 1ps
module keypad_decode_debounce_repeat_unit_test;
    import kdr_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [LINE_W-1:0] row;
        logic [LINE_W-1:0] col;
    } scan_t;

    // (col+1)*row signature per key, key number = index + 1
    localparam logic [PROD_W-1:0] KEY_SIG [KEY_COUNT] = '{
        8'd88, 8'd44, 8'd80, 8'd22,
        8'd40, 8'd72, 8'd36, 8'd10,
        8'd104, 8'd52, 8'd26, 8'd20,
        8'd18, 8'd13, 8'd9, 8'd11
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [LINE_W-1:0] row_lines = '0;
    logic [LINE_W-1:0] col_lines = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [KEY_W-1:0]  key_code;

    keypad_decode_debounce_repeat_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .row_lines (row_lines),
        .col_lines (col_lines),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .key_code  (key_code)
    );

    // tracker model state and its copy of the registers
    logic [CNT_W-1:0] cfg_confirm = CONFIRM_RST;
    logic [CNT_W-1:0] cfg_repeat  = REPEAT_RST;
    logic [CNT_W-1:0] cfg_release = RELEASE_RST;
    logic [KEY_W-1:0] trk_key     = '0;
    logic [CNT_W-1:0] trk_press   = '0;
    logic [CNT_W-1:0] trk_release = '0;

    scan_t            scan_q [$];
    logic [KEY_W-1:0] key_exp_q [$];
    scan_t            key_pair [1:KEY_COUNT][256];
    int               key_npairs [1:KEY_COUNT];

    int tx_idle_pct = 19;
    int rx_idle_pct = 19;
    int hold_req_cnt = 0;
    int hold_seen_cnt = 0;
    int hold_left = 0;
    int err_cnt = 0;
    int cycle_cnt = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [KEY_W-1:0] decode_key(input logic [LINE_W-1:0] row,
                                                    input logic [LINE_W-1:0] col);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] c;
        c = (row == '0) ? '0 : PROD_W'(col);
        prod = (c + 8'd1) * PROD_W'(row);
        for (int k = 0; k < KEY_COUNT; k++) begin
            if (prod == KEY_SIG[k])
                return KEY_W'(k + 1);
        end
        return '0;
    endfunction

    // advances the tracker by one scan and returns the code it reports
    function logic [KEY_W-1:0] track_scan(input logic [LINE_W-1:0] row,
                                          input logic [LINE_W-1:0] col);
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] rep;
        key = decode_key(row, col);
        rep = '0;
        if (key == '0) begin
            if (trk_press != '0) begin
                if (trk_release < cfg_release)
                    trk_release = trk_release + 8'd1;
                else
                    trk_press = '0;
            end
        end else if (key != trk_key) begin
            trk_key = key;
            trk_press = '0;
            trk_release = '0;
        end else begin
            trk_release = '0;
            trk_press = trk_press + 8'd1;
            // confirm compare wins over the repeat compare
            if (trk_press == cfg_confirm) begin
                rep = key;
            end else if (trk_press >= cfg_repeat) begin
                trk_press = cfg_repeat - 8'd1;
                rep = key;
            end
        end
        return rep;
    endfunction

    // scan driver
    always @(posedge clk) begin
        scan_t s;
        if (rst_n) begin
            if (in_valid && in_ready)
                key_exp_q.push_back(track_scan(row_lines, col_lines));
            if (!(in_valid && !in_ready)) begin
                if (scan_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    s = scan_q.pop_front();
                    in_valid <= 1'b1;
                    row_lines <= s.row;
                    col_lines <= s.col;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // key code monitor and receiver back-pressure
    always @(posedge clk) begin
        logic [KEY_W-1:0] want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (key_exp_q.size() == 0) begin
                    $display("%0t: unexpected key_code beat: expected none, actual %0d",
                             $time, key_code);
                    err_cnt++;
                end else begin
                    want = key_exp_q.pop_front();
                    if (key_code !== want) begin
                        $display("%0t: key_code mismatch: expected %0d, actual %0d",
                                 $time, want, key_code);
                        err_cnt++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (hold_seen_cnt != hold_req_cnt) begin
                hold_seen_cnt = hold_req_cnt;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d key codes outstanding", $time, key_exp_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [CNT_W-1:0] val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= DATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_CONFIRM: cfg_confirm = val;
            REG_REPEAT:  cfg_repeat = val;
            REG_RELEASE: cfg_release = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CNT_W-1:0] confirm, input logic [CNT_W-1:0] rpt,
                              input logic [CNT_W-1:0] rel);
        reg_write(REG_CONFIRM, confirm);
        reg_write(REG_REPEAT, rpt);
        reg_write(REG_RELEASE, rel);
    endtask

    // waits until every queued scan is sent and every key code has come back
    task automatic wait_drain();
        @(posedge clk);
        while (scan_q.size() != 0 || in_valid || key_exp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_scan(input logic [LINE_W-1:0] row, input logic [LINE_W-1:0] col);
        scan_q.push_back('{row: row, col: col});
    endtask

    task automatic push_empty();
        scan_t s;
        if ($urandom_range(0, 1) == 0) begin
            s = '{row: '0, col: LINE_W'($urandom_range(0, 15))};
        end else begin
            do
                s = scan_t'($urandom_range(0, 255));
            while (decode_key(s.row, s.col) != '0);
        end
        scan_q.push_back(s);
    endtask

    task automatic push_key(input int k);
        scan_q.push_back(key_pair[k][$urandom_range(0, key_npairs[k] - 1)]);
    endtask

    // mostly held keys with random wiring variants and short release gaps, some noise
    task automatic fill_phase(input int target);
        int n;
        int k;
        int len;
        int gmax;
        int g;
        n = 0;
        gmax = (cfg_release < 5) ? int'(cfg_release) + 2 : 6;
        while (n < target) begin
            if ($urandom_range(0, 9) < 7) begin
                k = $urandom_range(1, KEY_COUNT);
                if ($urandom_range(0, 3) == 0)
                    len = $urandom_range(int'(cfg_repeat), int'(cfg_repeat) + 12);
                else
                    len = $urandom_range(1, (cfg_confirm > 12 ? 12 : int'(cfg_confirm)) + 3);
                for (int i = 0; i < len; i++) begin
                    push_key(k);
                    n++;
                    if ($urandom_range(0, 7) == 0) begin
                        g = $urandom_range(1, gmax);
                        repeat (g) push_empty();
                        n += g;
                    end
                end
            end else begin
                g = $urandom_range(1, 4);
                repeat (g) scan_q.push_back(scan_t'($urandom_range(0, 255)));
                n += g;
            end
        end
    endtask

    initial begin
        scan_t s;
        for (int k = 1; k <= KEY_COUNT; k++)
            key_npairs[k] = 0;
        for (int v = 0; v < 256; v++) begin
            s = scan_t'(v);
            if (decode_key(s.row, s.col) != '0) begin
                key_pair[decode_key(s.row, s.col)][key_npairs[decode_key(s.row, s.col)]] = s;
                key_npairs[decode_key(s.row, s.col)]++;
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset config 3/48/2
        push_scan(4'd0, 4'd15);     // zero row masks the columns
        push_scan(4'd15, 4'd15);
        push_scan(4'd15, 4'd0);
        push_scan(4'd8, 4'd10);     // key 1 arrives
        push_scan(4'd11, 4'd7);     // same key, other wiring
        push_scan(4'd8, 4'd10);
        push_scan(4'd8, 4'd10);     // confirmed
        push_scan(4'd8, 4'd10);
        push_scan(4'd0, 4'd0);
        push_scan(4'd0, 4'd5);
        push_scan(4'd8, 4'd10);     // bounce within release window
        push_scan(4'd0, 4'd0);
        push_scan(4'd0, 4'd0);
        push_scan(4'd0, 4'd0);      // press count cleared here
        push_scan(4'd8, 4'd10);
        push_scan(4'd1, 4'd12);
        push_scan(4'd11, 4'd0);
        push_scan(4'd11, 4'd0);
        push_scan(4'd1, 4'd10);
        push_scan(4'd11, 4'd0);
        push_scan(4'd15, 4'd15);
        push_scan(4'd9, 4'd0);
        push_scan(4'd13, 4'd7);
        push_scan(4'd4, 4'd4);
        push_scan(4'd2, 4'd8);
        wait_drain();

        set_config(8'd1, 8'd2, 8'd0);
        fill_phase(210);
        hold_req_cnt++;
        wait_drain();

        // no idling on either side for this stretch
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_config(8'd255, 8'd255, 8'd254);
        fill_phase(210);
        wait_drain();
        tx_idle_pct = 19;
        rx_idle_pct = 19;

        // repeat threshold below confirm: repeat path only
        set_config(8'd5, 8'd4, 8'd3);
        fill_phase(210);
        hold_req_cnt++;
        wait_drain();

        set_config(8'd2, 8'd10, 8'd1);
        fill_phase(210);
        wait_drain();

        repeat (2) begin
            set_config(CNT_W'($urandom_range(1, 255)), CNT_W'($urandom_range(2, 64)),
                       CNT_W'($urandom_range(0, 254)));
            fill_phase(200);
            hold_req_cnt++;
            wait_drain();
        end

        repeat (10) @(posedge clk);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
design/kdr_pkg.sv
design/kdr_decode.sv
design/kdr_track.sv
design/keypad_decode_debounce_repeat_unit.sv
tb/sv/keypad_decode_debounce_repeat_unit_test.sv
